[rtl/rle_pkg.sv]
// ----------------------------------------------------------------------------
// rle_pkg
// Shared constants, types and helpers of the bit run-length encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rle_pkg;

  localparam int MAX_WIDTH  = 16;
  localparam int CNT_W      = 16;
  localparam int CFG_W      = 5;
  localparam int BYTE_W     = 8;
  localparam int NUM_LANES  = BYTE_W;
  localparam int NUM_SLOTS  = 2 * NUM_LANES + 1;
  localparam int SLOT_IDX_W = $clog2(NUM_SLOTS);
  localparam int FLUSH_SLOT = 2 * NUM_LANES;
  localparam int OUT_DATA_W = 24;
  localparam logic [CFG_W-1:0] RESET_WIDTH = CFG_W'(8);

  // State of the open run between bits.
  typedef struct packed {
    logic             started;
    logic             run_bit;
    logic [CNT_W-1:0] count;
  } run_state_t;

  // What one bit lane found: a finished run, and possibly a zero-length filler.
  typedef struct packed {
    logic             run_valid;
    logic [CNT_W-1:0] run_len;
    logic             run_bit;
    logic             fill_valid;
    logic             fill_bit;
  } lane_emit_t;

  // One pending result.
  typedef struct packed {
    logic [CNT_W-1:0] len;
    logic             run_bit;
    logic             eom;
  } slot_t;

  // Maximum run length for a given width, clamped to the legal range.
  function automatic logic [CNT_W-1:0] max_run(input logic [CFG_W-1:0] width);
    logic [5:0]  w;
    logic [32:0] span;
    w = {1'b0, width};
    if (w < 6'd1) begin
      w = 6'd1;
    end
    if (int'(w) > MAX_WIDTH) begin
      w = 6'(MAX_WIDTH);
    end
    if (w > 6'd32) begin
      w = 6'd32;
    end
    span = (33'd1 << w) - 33'd1;
    if (span > 33'(2 ** CNT_W - 1)) begin
      span = 33'(2 ** CNT_W - 1);
    end
    return span[CNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/bit_run_length_encoder.sv]
// ----------------------------------------------------------------------------
// bit_run_length_encoder
// Counts runs of equal bits over a byte stream, MSB first, and sends one
// result per finished run, splitting runs that exceed the maximum length.
// ----------------------------------------------------------------------------
//   Port group  Dir  Contents
//   in_*        in   data_byte in tdata[7:0], last_byte on tlast
//   out_*       out  run_length, run_bit, last_of_item in tdata; end on tlast
//   cfg_*       in   run_width in cfg_data[4:0]
//
// Eight bit lanes process a whole byte in the cycle it is accepted. A byte
// that yields at most one result is taken every cycle; otherwise the next
// byte waits until its results (up to seventeen) have drained through the
// output register, one per cycle. Reset is synchronous and needs no clearing
// pass. Output stalls hold the result register and hold off new bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bit_run_length_encoder (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [7:0] data_byte
  input  logic [rle_pkg::BYTE_W-1:0]        in_tdata,
  // last_byte
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [15:0] run_length, [16] run_bit, [17] last_of_item, [23:18] zero
  output logic [rle_pkg::OUT_DATA_W-1:0]    out_tdata,
  // end_of_message
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rle_pkg::CFG_W-1:0]         cfg_data
);
  import rle_pkg::*;

  logic [CNT_W-1:0]     m_r;
  run_state_t           state_r, state_nxt;
  run_state_t           chain [NUM_LANES+1];
  lane_emit_t           emit [NUM_LANES];
  slot_t                slots [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] slot_valid;
  logic                 accept;
  logic                 load_ok;

  assign cfg_ready = 1'b1;
  assign accept    = in_tvalid && in_tready;
  assign in_tready = load_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r <= max_run(RESET_WIDTH);
    end else if (cfg_valid) begin
      m_r <= max_run(cfg_data);
    end
  end

  assign chain[0] = state_r;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    rle_lane u_lane (
      .st_i   (chain[g]),
      .bit_i  (in_tdata[BYTE_W-1-g]),
      .max_i  (m_r),
      .st_o   (chain[g+1]),
      .emit_o (emit[g])
    );
  end

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      slots[2*i].len         = emit[i].run_len;
      slots[2*i].run_bit     = emit[i].run_bit;
      slots[2*i].eom         = 1'b0;
      slot_valid[2*i]        = emit[i].run_valid;
      slots[2*i+1].len       = '0;
      slots[2*i+1].run_bit   = emit[i].fill_bit;
      slots[2*i+1].eom       = 1'b0;
      slot_valid[2*i+1]      = emit[i].fill_valid;
    end
    // The final byte flushes whatever run is still open.
    slots[FLUSH_SLOT].len     = (chain[NUM_LANES].count > m_r) ? m_r
                                                               : chain[NUM_LANES].count;
    slots[FLUSH_SLOT].run_bit = chain[NUM_LANES].run_bit;
    slots[FLUSH_SLOT].eom     = 1'b1;
    slot_valid[FLUSH_SLOT]    = in_tlast;
  end

  always_comb begin
    state_nxt = state_r;
    if (accept) begin
      state_nxt = in_tlast ? '0 : chain[NUM_LANES];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else begin
      state_r <= state_nxt;
    end
  end

  rle_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (accept),
    .valid_i    (slot_valid),
    .slots_i    (slots),
    .load_ok_o  (load_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

[rtl/rle_lane.sv]
// ----------------------------------------------------------------------------
// rle_lane
// One bit position: advances the open run by one bit and reports the runs
// that this bit closes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rle_lane (
  input  rle_pkg::run_state_t           st_i,
  input  logic                          bit_i,
  input  logic [rle_pkg::CNT_W-1:0]     max_i,
  output rle_pkg::run_state_t           st_o,
  output rle_pkg::lane_emit_t           emit_o
);
  import rle_pkg::*;

  always_comb begin
    st_o   = st_i;
    emit_o = '0;
    if (!st_i.started) begin
      st_o.started = 1'b1;
      st_o.run_bit = bit_i;
      st_o.count   = CNT_W'(1);
    end else if (bit_i != st_i.run_bit) begin
      emit_o.run_valid = 1'b1;
      emit_o.run_len   = (st_i.count > max_i) ? max_i : st_i.count;
      emit_o.run_bit   = st_i.run_bit;
      st_o.run_bit     = bit_i;
      st_o.count       = CNT_W'(1);
    end else if (st_i.count >= max_i) begin
      // Run is full: send the maximum, then an empty run of the other bit.
      emit_o.run_valid  = 1'b1;
      emit_o.run_len    = max_i;
      emit_o.run_bit    = st_i.run_bit;
      emit_o.fill_valid = 1'b1;
      emit_o.fill_bit   = ~st_i.run_bit;
      st_o.count        = CNT_W'(1);
    end else begin
      st_o.count = st_i.count + CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

[rtl/rle_merge.sv]
// ----------------------------------------------------------------------------
// rle_merge
// Holds the results of one item in slot order and hands them to the output
// register one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rle_merge (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load_i,
  input  logic [rle_pkg::NUM_SLOTS-1:0]     valid_i,
  input  rle_pkg::slot_t                    slots_i [rle_pkg::NUM_SLOTS],
  output logic                              load_ok_o,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [15:0] run_length, [16] run_bit, [17] last_of_item, [23:18] zero
  output logic [rle_pkg::OUT_DATA_W-1:0]    out_tdata,
  // end_of_message
  output logic                              out_tlast
);
  import rle_pkg::*;

  logic [NUM_SLOTS-1:0]  pend_r, pend_nxt;
  slot_t                 slots_r [NUM_SLOTS];
  logic                  out_valid_r, out_valid_nxt;
  slot_t                 out_slot_r, out_slot_nxt;
  logic                  out_lio_r, out_lio_nxt;
  logic [SLOT_IDX_W-1:0] sel;
  logic [NUM_SLOTS-1:0]  sel_mask;
  logic [NUM_SLOTS-1:0]  rest;
  logic                  move;

  always_comb begin
    sel = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        sel = SLOT_IDX_W'(i);
      end
    end
  end

  assign sel_mask  = NUM_SLOTS'(1) << sel;
  assign rest      = pend_r & ~sel_mask;
  assign move      = (pend_r != '0) && (!out_valid_r || out_tready);
  // A new item may come in once the last pending result leaves this cycle.
  assign load_ok_o = (pend_r == '0) || (move && (rest == '0));

  always_comb begin
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    out_slot_nxt  = out_slot_r;
    out_lio_nxt   = out_lio_r;
    if (move) begin
      pend_nxt      = rest;
      out_valid_nxt = 1'b1;
      out_slot_nxt  = slots_r[sel];
      out_lio_nxt   = (rest == '0);
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_i) begin
      pend_nxt = valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_slot_r <= out_slot_nxt;
    out_lio_r  <= out_lio_nxt;
    if (load_i) begin
      slots_r <= slots_i;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - CNT_W - 2)'(0), out_lio_r, out_slot_r.run_bit,
                       out_slot_r.len};
  assign out_tlast  = out_slot_r.eom;

endmodule

`default_nettype wire
